[hw/rtl/pnm_hdr_pkg.sv]
// Shared types and constants for the PNM header parser.
`default_nettype none

package pnm_hdr_pkg;

  // Width of the dimension fields on the result channel.
  localparam int OUT_DIM_BITS = 16;

  // Decimal radix used when accumulating width and height digits.
  localparam int DEC_RADIX = 10;

  typedef enum logic [3:0] {
    PH_MAGIC_P = 4'd0,
    PH_MAGIC_D = 4'd1,
    PH_WS_W    = 4'd2,
    PH_WIDTH   = 4'd3,
    PH_WS_H    = 4'd4,
    PH_HEIGHT  = 4'd5,
    PH_WS_M    = 4'd6,
    PH_MAXV    = 4'd7,
    PH_TERM    = 4'd8,
    PH_PAYLOAD = 4'd9,
    PH_ERROR   = 4'd10
  } phase_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MAGIC   = 2'd1;
  localparam logic [1:0] ST_COMMENT = 2'd2;
  localparam logic [1:0] ST_TERM    = 2'd3;

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_BEGIN = 1'b1;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]              out_byte;
    logic                    byte_valid;
    logic                    is_payload;
    logic                    header_done;
    logic [OUT_DIM_BITS-1:0] image_width;
    logic [OUT_DIM_BITS-1:0] image_height;
    logic [1:0]              status;
  } result_t;

  // Parser control state carried between the state registers and the step logic.
  typedef struct packed {
    phase_t     phase;
    logic       has_max_field;
    logic [1:0] error_code;
  } ctl_t;

endpackage

`default_nettype wire

[hw/rtl/pnm_hdr_step.sv]
// Combinational parse step: next parser state and result for one byte.
`default_nettype none

module pnm_hdr_step #(
  parameter int DIM_BITS = 16
) (
  input  pnm_hdr_pkg::item_t   item,
  input  pnm_hdr_pkg::ctl_t    ctl,
  input  logic [DIM_BITS-1:0]  width_accum,
  input  logic [DIM_BITS-1:0]  height_accum,
  output pnm_hdr_pkg::ctl_t    ctl_next,
  output logic [DIM_BITS-1:0]  width_accum_next,
  output logic [DIM_BITS-1:0]  height_accum_next,
  output pnm_hdr_pkg::result_t res
);

  localparam int ACC_BITS = DIM_BITS + 4;
  localparam int EXT_BITS =
    (DIM_BITS > pnm_hdr_pkg::OUT_DIM_BITS) ? DIM_BITS : pnm_hdr_pkg::OUT_DIM_BITS;

  logic       is_ws;
  logic       is_digit;
  logic       is_hash;
  logic       payload;
  logic       done;
  logic       fail;
  logic [1:0] fail_code;
  logic [EXT_BITS-1:0] width_ext;
  logic [EXT_BITS-1:0] height_ext;

  // acc * 10 + digit, saturating at the all-ones dimension value.
  function automatic logic [DIM_BITS-1:0] accum(input logic [DIM_BITS-1:0] acc,
                                                input logic [7:0] b);
    logic [ACC_BITS-1:0] v;
    v = ACC_BITS'(acc) * ACC_BITS'(pnm_hdr_pkg::DEC_RADIX) +
        ACC_BITS'(b - pnm_hdr_pkg::CH_0);
    if (v[ACC_BITS-1:DIM_BITS] != 4'd0) begin
      return {DIM_BITS{1'b1}};
    end
    return v[DIM_BITS-1:0];
  endfunction

  assign is_ws = (item.data_byte == pnm_hdr_pkg::CH_SPACE) ||
                 (item.data_byte == pnm_hdr_pkg::CH_TAB) ||
                 (item.data_byte == pnm_hdr_pkg::CH_CR) ||
                 (item.data_byte == pnm_hdr_pkg::CH_LF);
  assign is_digit = (item.data_byte >= pnm_hdr_pkg::CH_0) &&
                    (item.data_byte <= pnm_hdr_pkg::CH_9);
  assign is_hash = (item.data_byte == pnm_hdr_pkg::CH_HASH);

  // A byte that does not fit the current field falls through the following
  // phases within the same cycle; each arm below is that chain worked out by
  // byte class. Any other byte in a whitespace or field phase runs through
  // to the terminator check and fails there.
  always_comb begin
    ctl_next          = ctl;
    width_accum_next  = width_accum;
    height_accum_next = height_accum;
    payload           = 1'b0;
    done              = 1'b0;
    fail              = 1'b0;
    fail_code         = pnm_hdr_pkg::ST_OK;
    if (item.cmd == pnm_hdr_pkg::CMD_BEGIN) begin
      ctl_next.phase         = pnm_hdr_pkg::PH_MAGIC_P;
      ctl_next.has_max_field = 1'b0;
      ctl_next.error_code    = pnm_hdr_pkg::ST_OK;
      width_accum_next       = '0;
      height_accum_next      = '0;
    end else begin
      unique case (ctl.phase) inside
        pnm_hdr_pkg::PH_MAGIC_P: begin
          if (item.data_byte == pnm_hdr_pkg::CH_P) begin
            ctl_next.phase = pnm_hdr_pkg::PH_MAGIC_D;
          end else begin
            fail      = 1'b1;
            fail_code = pnm_hdr_pkg::ST_MAGIC;
          end
        end
        pnm_hdr_pkg::PH_MAGIC_D: begin
          if (item.data_byte == pnm_hdr_pkg::CH_4) begin
            ctl_next.has_max_field = 1'b0;
            ctl_next.phase         = pnm_hdr_pkg::PH_WS_W;
          end else if (item.data_byte == pnm_hdr_pkg::CH_5 ||
                       item.data_byte == pnm_hdr_pkg::CH_6) begin
            ctl_next.has_max_field = 1'b1;
            ctl_next.phase         = pnm_hdr_pkg::PH_WS_W;
          end else begin
            fail      = 1'b1;
            fail_code = pnm_hdr_pkg::ST_MAGIC;
          end
        end
        pnm_hdr_pkg::PH_WS_W: begin
          if (is_hash) begin
            fail      = 1'b1;
            fail_code = pnm_hdr_pkg::ST_COMMENT;
          end else if (is_digit) begin
            ctl_next.phase   = pnm_hdr_pkg::PH_WIDTH;
            width_accum_next = accum(width_accum, item.data_byte);
          end else if (!is_ws) begin
            fail      = 1'b1;
            fail_code = pnm_hdr_pkg::ST_TERM;
          end
        end
        pnm_hdr_pkg::PH_WIDTH: begin
          if (is_digit) begin
            width_accum_next = accum(width_accum, item.data_byte);
          end else if (is_ws) begin
            ctl_next.phase = pnm_hdr_pkg::PH_WS_H;
          end else if (is_hash) begin
            fail      = 1'b1;
            fail_code = pnm_hdr_pkg::ST_COMMENT;
          end else begin
            fail      = 1'b1;
            fail_code = pnm_hdr_pkg::ST_TERM;
          end
        end
        pnm_hdr_pkg::PH_WS_H: begin
          if (is_hash) begin
            fail      = 1'b1;
            fail_code = pnm_hdr_pkg::ST_COMMENT;
          end else if (is_digit) begin
            ctl_next.phase    = pnm_hdr_pkg::PH_HEIGHT;
            height_accum_next = accum(height_accum, item.data_byte);
          end else if (!is_ws) begin
            fail      = 1'b1;
            fail_code = pnm_hdr_pkg::ST_TERM;
          end
        end
        pnm_hdr_pkg::PH_HEIGHT: begin
          if (is_digit) begin
            height_accum_next = accum(height_accum, item.data_byte);
          end else if (is_ws) begin
            if (ctl.has_max_field) begin
              ctl_next.phase = pnm_hdr_pkg::PH_WS_M;
            end else begin
              ctl_next.phase = pnm_hdr_pkg::PH_PAYLOAD;
              done           = 1'b1;
            end
          end else if (is_hash && ctl.has_max_field) begin
            fail      = 1'b1;
            fail_code = pnm_hdr_pkg::ST_COMMENT;
          end else begin
            fail      = 1'b1;
            fail_code = pnm_hdr_pkg::ST_TERM;
          end
        end
        pnm_hdr_pkg::PH_WS_M: begin
          if (is_hash) begin
            fail      = 1'b1;
            fail_code = pnm_hdr_pkg::ST_COMMENT;
          end else if (is_digit) begin
            ctl_next.phase = pnm_hdr_pkg::PH_MAXV;
          end else if (!is_ws) begin
            fail      = 1'b1;
            fail_code = pnm_hdr_pkg::ST_TERM;
          end
        end
        pnm_hdr_pkg::PH_MAXV, pnm_hdr_pkg::PH_TERM: begin
          if (is_ws) begin
            ctl_next.phase = pnm_hdr_pkg::PH_PAYLOAD;
            done           = 1'b1;
          end else if (!(is_digit && ctl.phase == pnm_hdr_pkg::PH_MAXV)) begin
            fail      = 1'b1;
            fail_code = pnm_hdr_pkg::ST_TERM;
          end
        end
        pnm_hdr_pkg::PH_PAYLOAD: begin
          payload = 1'b1;
        end
        default: begin
          // Error phase and unused codes: the parser holds still.
        end
      endcase
    end
    if (fail) begin
      ctl_next.phase = pnm_hdr_pkg::PH_ERROR;
      if (ctl.error_code == pnm_hdr_pkg::ST_OK) begin
        ctl_next.error_code = fail_code;
      end
    end
  end

  assign width_ext  = EXT_BITS'(width_accum_next);
  assign height_ext = EXT_BITS'(height_accum_next);

  always_comb begin
    res.out_byte     = (item.cmd == pnm_hdr_pkg::CMD_BEGIN) ? 8'd0 : item.data_byte;
    res.byte_valid   = (item.cmd == pnm_hdr_pkg::CMD_DATA);
    res.is_payload   = payload;
    res.header_done  = done;
    res.image_width  = width_ext[pnm_hdr_pkg::OUT_DIM_BITS-1:0];
    res.image_height = height_ext[pnm_hdr_pkg::OUT_DIM_BITS-1:0];
    res.status       = ctl_next.error_code;
  end

endmodule

`default_nettype wire

[hw/rtl/pnm_header_parser_unit.sv]
// Binary PNM header parser with byte pass-through.
//
// Items arrive on the item channel (item_valid/item_ready) as a command bit
// and a byte. A begin-of-image command resets the parser and yields a result
// with byte_valid low; a data byte is forwarded on the result channel
// (result_valid/result_ready) tagged as header or payload, together with the
// width and height parsed so far and a sticky status code.
// An accepted item lands in an input register; when the result register is
// free or being taken, one short combinational parse step updates the parser
// state and loads the result register, raising result_valid. The block takes
// one item per cycle as long as results are taken.
// When the receiver stalls, the result register holds and the input register
// absorbs one more item; item_ready drops only when both are full.
// Synchronous reset empties both registers and returns the parser to the
// start of a header with zero dimensions and status ok.
`default_nettype none

module pnm_header_parser_unit #(
  parameter int DIM_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  pnm_hdr_pkg::item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output pnm_hdr_pkg::result_t result
);

  logic                 s0_valid;
  pnm_hdr_pkg::item_t   s0_item;
  pnm_hdr_pkg::ctl_t    ctl;
  pnm_hdr_pkg::ctl_t    ctl_next;
  logic [DIM_BITS-1:0]  width_accum;
  logic [DIM_BITS-1:0]  width_accum_next;
  logic [DIM_BITS-1:0]  height_accum;
  logic [DIM_BITS-1:0]  height_accum_next;
  pnm_hdr_pkg::result_t step_res;
  logic                 advance;

  assign advance    = s0_valid && (!result_valid || result_ready);
  assign item_ready = !s0_valid || advance;

  pnm_hdr_step #(
    .DIM_BITS (DIM_BITS)
  ) u_step (
    .item              (s0_item),
    .ctl               (ctl),
    .width_accum       (width_accum),
    .height_accum      (height_accum),
    .ctl_next          (ctl_next),
    .width_accum_next  (width_accum_next),
    .height_accum_next (height_accum_next),
    .res               (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      s0_valid <= 1'b1;
    end else if (advance) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s0_item <= item;
    end
  end

  // Parser state moves only when the held transaction is committed to the
  // result register, so results leave in the order items were taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.phase         <= pnm_hdr_pkg::PH_MAGIC_P;
      ctl.has_max_field <= 1'b0;
      ctl.error_code    <= pnm_hdr_pkg::ST_OK;
      width_accum       <= '0;
      height_accum      <= '0;
    end else if (advance) begin
      ctl          <= ctl_next;
      width_accum  <= width_accum_next;
      height_accum <= height_accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_res;
    end
  end

endmodule

`default_nettype wire
